@@ sv/mss_pkg.sv @@
package mss_pkg;

  // fixed field widths
  localparam int OFF_W     = 36;
  localparam int LEN_W     = 32;
  localparam int HS_W      = 33;
  localparam int CNT_CFG_W = 5;
  localparam int DEVID_W   = 4;
  localparam int ST_W      = 2;
  localparam int PC_W      = 4;

  localparam logic [HS_W-1:0]      HALF_MAX    = 33'h1_0000_0000;
  localparam logic [HS_W-1:0]      HALF_RESET  = 33'd1048576;
  localparam logic [CNT_CFG_W-1:0] COUNT_RESET = 5'd4;

  // register indexes
  localparam logic REG_HALF_SIZE    = 1'b0;
  localparam logic REG_DEVICE_COUNT = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_OOR   = 2'd1;
  localparam logic [ST_W-1:0] STAT_TRUNC = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SUB,
    OP_SETUP,
    OP_PIECE,
    OP_ADV
  } op_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_PRI,
    EM_BAK,
    EM_OOR
  } emit_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_ID_EQ_CNT,
    C_POFF_GE_HS,
    C_OUT_STALL,
    C_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    emit_t           emit;
    logic            accept;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
  } ctl_t;

  typedef struct packed {
    logic id_eq_cnt;
    logic poff_ge_hs;
    logic more;
  } flags_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_DCHK  = 4'd1;
  localparam logic [PC_W-1:0] PC_DSUB  = 4'd2;
  localparam logic [PC_W-1:0] PC_SETUP = 4'd3;
  localparam logic [PC_W-1:0] PC_PIECE = 4'd4;
  localparam logic [PC_W-1:0] PC_EMITP = 4'd5;
  localparam logic [PC_W-1:0] PC_EMITB = 4'd6;
  localparam logic [PC_W-1:0] PC_ADV   = 4'd7;
  localparam logic [PC_W-1:0] PC_RET   = 4'd8;
  localparam logic [PC_W-1:0] PC_OOR   = 4'd9;
  localparam logic [PC_W-1:0] PC_ORET  = 4'd10;

  // control store
  function automatic ctl_t rom(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{op: OP_NONE, emit: EM_NONE, accept: 1'b0, cond: C_ALWAYS, tgt: PC_IDLE};
    unique case (pc)
      PC_IDLE:  w = '{op: OP_LOAD,  emit: EM_NONE, accept: 1'b1, cond: C_NO_IN,
                      tgt: PC_IDLE};
      PC_DCHK:  w = '{op: OP_NONE,  emit: EM_NONE, accept: 1'b0, cond: C_ID_EQ_CNT,
                      tgt: PC_OOR};
      PC_DSUB:  w = '{op: OP_SUB,   emit: EM_NONE, accept: 1'b0, cond: C_POFF_GE_HS,
                      tgt: PC_DCHK};
      PC_SETUP: w = '{op: OP_SETUP, emit: EM_NONE, accept: 1'b0, cond: C_NEVER,
                      tgt: PC_IDLE};
      PC_PIECE: w = '{op: OP_PIECE, emit: EM_NONE, accept: 1'b0, cond: C_NEVER,
                      tgt: PC_IDLE};
      PC_EMITP: w = '{op: OP_NONE,  emit: EM_PRI,  accept: 1'b0, cond: C_OUT_STALL,
                      tgt: PC_EMITP};
      PC_EMITB: w = '{op: OP_NONE,  emit: EM_BAK,  accept: 1'b0, cond: C_OUT_STALL,
                      tgt: PC_EMITB};
      PC_ADV:   w = '{op: OP_ADV,   emit: EM_NONE, accept: 1'b0, cond: C_MORE,
                      tgt: PC_PIECE};
      PC_RET:   w = '{op: OP_NONE,  emit: EM_NONE, accept: 1'b0, cond: C_ALWAYS,
                      tgt: PC_IDLE};
      PC_OOR:   w = '{op: OP_NONE,  emit: EM_OOR,  accept: 1'b0, cond: C_OUT_STALL,
                      tgt: PC_OOR};
      PC_ORET:  w = '{op: OP_NONE,  emit: EM_NONE, accept: 1'b0, cond: C_ALWAYS,
                      tgt: PC_IDLE};
      default:  w = '{op: OP_NONE,  emit: EM_NONE, accept: 1'b0, cond: C_ALWAYS,
                      tgt: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ sv/mss_seq.sv @@
module mss_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_stall,
  input  mss_pkg::flags_t flags,
  output mss_pkg::ctl_t   ctl
);

  logic [mss_pkg::PC_W-1:0] pc_r;
  logic [mss_pkg::PC_W-1:0] pc_nxt;
  logic                     take;

  assign ctl = mss_pkg::rom(pc_r);

  always_comb begin
    unique case (ctl.cond)
      mss_pkg::C_NEVER:      take = 1'b0;
      mss_pkg::C_ALWAYS:     take = 1'b1;
      mss_pkg::C_NO_IN:      take = ~in_valid;
      mss_pkg::C_ID_EQ_CNT:  take = flags.id_eq_cnt;
      mss_pkg::C_POFF_GE_HS: take = flags.poff_ge_hs;
      mss_pkg::C_OUT_STALL:  take = out_stall;
      mss_pkg::C_MORE:       take = flags.more;
      default:               take = 1'b1;
    endcase
  end

  assign pc_nxt = take ? ctl.tgt : pc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mss_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ sv/mss_dp.sv @@
module mss_dp #(
  parameter int MAX_DEVICES = 16,
  parameter int MAX_PAIRS   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mss_pkg::ctl_t                    ctl,
  input  logic [mss_pkg::OFF_W-1:0]        in_start_offset,
  input  logic [mss_pkg::LEN_W-1:0]        in_length,
  input  logic [mss_pkg::HS_W-1:0]         half_size,
  input  logic [mss_pkg::CNT_CFG_W-1:0]    device_count,
  output mss_pkg::flags_t                  flags,
  output logic [mss_pkg::DEVID_W-1:0]      out_device_id,
  output logic [mss_pkg::HS_W-1:0]         out_device_offset,
  output logic [mss_pkg::LEN_W-1:0]        out_piece_length,
  output logic                             out_mirror,
  output logic [mss_pkg::ST_W-1:0]         out_status,
  output logic                             out_last
);

  localparam int ID_W   = $clog2(MAX_DEVICES + 1);
  localparam int PAIR_W = $clog2(MAX_PAIRS + 1);
  localparam int CW     = (ID_W > mss_pkg::CNT_CFG_W) ? ID_W : mss_pkg::CNT_CFG_W;
  localparam int EXT_W  = mss_pkg::OFF_W - mss_pkg::HS_W;

  logic [mss_pkg::HS_W-1:0]  hs_eff;
  logic [CW-1:0]             cnt_w;
  logic [ID_W-1:0]           cnt_eff;
  logic [mss_pkg::OFF_W-1:0] hs_ext;

  logic [mss_pkg::OFF_W-1:0] poff_r;
  logic [ID_W-1:0]           id_r;
  logic [mss_pkg::LEN_W-1:0] rem_r;
  logic [mss_pkg::HS_W-1:0]  room_r;
  logic [mss_pkg::LEN_W-1:0] piece_r;
  logic [PAIR_W-1:0]         pairs_r;
  logic                      fin_r;
  logic                      trunc_r;

  logic [ID_W-1:0]           id_inc;
  logic [ID_W-1:0]           bid;
  logic                      rem_le_room;
  logic [mss_pkg::LEN_W-1:0] piece;
  logic                      last_pair;

  // effective configuration: clamp half size and ring size
  always_comb begin
    if (half_size == '0) begin
      hs_eff = mss_pkg::HS_W'(1);
    end else if (half_size > mss_pkg::HALF_MAX) begin
      hs_eff = mss_pkg::HALF_MAX;
    end else begin
      hs_eff = half_size;
    end
    cnt_w = CW'(device_count);
    if (cnt_w < CW'(2)) begin
      cnt_w = CW'(2);
    end else if (cnt_w > CW'(MAX_DEVICES)) begin
      cnt_w = CW'(MAX_DEVICES);
    end
    cnt_eff = ID_W'(cnt_w);
  end

  assign hs_ext      = {{EXT_W{1'b0}}, hs_eff};
  assign id_inc      = id_r + 1'b1;
  assign bid         = (id_inc == cnt_eff) ? '0 : id_inc;
  assign rem_le_room = {1'b0, rem_r} <= room_r;
  assign piece       = rem_le_room ? rem_r : room_r[mss_pkg::LEN_W-1:0];
  assign last_pair   = (pairs_r == PAIR_W'(MAX_PAIRS - 1));

  assign flags.id_eq_cnt  = (id_r == cnt_eff);
  assign flags.poff_ge_hs = (poff_r >= hs_ext);
  assign flags.more       = ~(fin_r | trunc_r);

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      mss_pkg::OP_LOAD: begin
        poff_r <= in_start_offset;
        rem_r  <= in_length;
        id_r   <= '0;
      end
      mss_pkg::OP_SUB: begin
        if (flags.poff_ge_hs) begin
          poff_r <= poff_r - hs_ext;
          id_r   <= id_inc;
        end
      end
      mss_pkg::OP_SETUP: begin
        room_r <= hs_eff - poff_r[mss_pkg::HS_W-1:0];
      end
      mss_pkg::OP_PIECE: begin
        piece_r <= piece;
      end
      mss_pkg::OP_ADV: begin
        rem_r  <= rem_r - piece_r;
        id_r   <= bid;
        poff_r <= '0;
        room_r <= hs_eff;
      end
      default: begin
      end
    endcase
  end

  // pair count and end-of-request flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= '0;
      fin_r   <= 1'b0;
      trunc_r <= 1'b0;
    end else begin
      case (ctl.op)
        mss_pkg::OP_SETUP: pairs_r <= '0;
        mss_pkg::OP_PIECE: begin
          fin_r   <= rem_le_room;
          trunc_r <= ~rem_le_room & last_pair;
        end
        mss_pkg::OP_ADV:   pairs_r <= pairs_r + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_device_id     = '0;
    out_device_offset = '0;
    out_piece_length  = '0;
    out_mirror        = 1'b0;
    out_status        = mss_pkg::STAT_OK;
    out_last          = 1'b0;
    unique case (ctl.emit)
      mss_pkg::EM_PRI: begin
        out_device_id     = mss_pkg::DEVID_W'(id_r);
        out_device_offset = poff_r[mss_pkg::HS_W-1:0];
        out_piece_length  = piece_r;
      end
      mss_pkg::EM_BAK: begin
        out_device_id     = mss_pkg::DEVID_W'(bid);
        out_device_offset = poff_r[mss_pkg::HS_W-1:0] + hs_eff;
        out_piece_length  = piece_r;
        out_mirror        = 1'b1;
        out_status        = trunc_r ? mss_pkg::STAT_TRUNC : mss_pkg::STAT_OK;
        out_last          = fin_r | trunc_r;
      end
      mss_pkg::EM_OOR: begin
        out_status = mss_pkg::STAT_OOR;
        out_last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/mirrored_stripe_request_splitter.sv @@
// steps: accept, locate device q = offset / half_size (one compare-and-subtract
// per device), setup, then for each primary/mirror pair a sizing, primary,
// mirror and advance step with output stalls holding each result, and a return step
// one request at a time: no new request is taken until the last result is out
// out-of-range offsets: single result
// reset: synchronous active-low rst_n idles the sequencer, half_size 1048576, device_count 4
module mirrored_stripe_request_splitter #(
  parameter int MAX_DEVICES = 16,
  parameter int MAX_PAIRS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mss_pkg::OFF_W-1:0]     in_start_offset,
  input  logic [mss_pkg::LEN_W-1:0]     in_length,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mss_pkg::DEVID_W-1:0]   out_device_id,
  output logic [mss_pkg::HS_W-1:0]      out_device_offset,
  output logic [mss_pkg::LEN_W-1:0]     out_piece_length,
  output logic                          out_mirror,
  output logic [mss_pkg::ST_W-1:0]      out_status,
  output logic                          out_last,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [mss_pkg::HS_W-1:0]      cfg_wr_data
);

  mss_pkg::ctl_t   ctl;
  mss_pkg::flags_t flags;

  logic [mss_pkg::HS_W-1:0]      half_size_r;
  logic [mss_pkg::CNT_CFG_W-1:0] device_count_r;

  // config registers, to be written only while the block is idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_size_r    <= mss_pkg::HALF_RESET;
      device_count_r <= mss_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == mss_pkg::REG_HALF_SIZE) begin
        half_size_r <= cfg_wr_data;
      end else begin
        device_count_r <= cfg_wr_data[mss_pkg::CNT_CFG_W-1:0];
      end
    end
  end

  // sequencer: step counter plus control store
  mss_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .ctl       (ctl)
  );

  // datapath: divide loop, piece sizing, result fields
  mss_dp #(
    .MAX_DEVICES (MAX_DEVICES),
    .MAX_PAIRS   (MAX_PAIRS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .in_start_offset   (in_start_offset),
    .in_length         (in_length),
    .half_size         (half_size_r),
    .device_count      (device_count_r),
    .flags             (flags),
    .out_device_id     (out_device_id),
    .out_device_offset (out_device_offset),
    .out_piece_length  (out_piece_length),
    .out_mirror        (out_mirror),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  // handshake comes straight from the current control word, no item taken in reset
  assign in_stall  = ~ctl.accept | ~rst_n;
  assign out_valid = (ctl.emit != mss_pkg::EM_NONE);

  // no new item is taken while a result is being offered
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item taken while result pending");

  // a primary copy never closes a request
  a_primary_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mirror && out_status == mss_pkg::STAT_OK) |-> !out_last)
    else $error("primary result marked last");

  // truncation and out-of-range status only on the closing result
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == mss_pkg::STAT_TRUNC || out_status == mss_pkg::STAT_OOR))
      |-> out_last)
    else $error("error status on non-final result");

  // after the closing result is taken, no result is offered next cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("result offered right after last");

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DEV   = 16;
  localparam int N_PAIRS = 32;

  // one request as offered on the input channel
  typedef struct {
    logic [mss_pkg::OFF_W-1:0] offs;
    logic [mss_pkg::LEN_W-1:0] len;
  } req_t;

  // one piece as it should come out of the block
  typedef struct {
    logic [mss_pkg::DEVID_W-1:0] dev;
    logic [mss_pkg::HS_W-1:0]    offs;
    logic [mss_pkg::LEN_W-1:0]   len;
    logic                        bk;
    logic [mss_pkg::ST_W-1:0]    st;
    logic                        is_last;
  } piece_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [mss_pkg::OFF_W-1:0]     in_start_offset = '0;
  logic [mss_pkg::LEN_W-1:0]     in_length = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [mss_pkg::DEVID_W-1:0]   out_device_id;
  logic [mss_pkg::HS_W-1:0]      out_device_offset;
  logic [mss_pkg::LEN_W-1:0]     out_piece_length;
  logic                          out_mirror;
  logic [mss_pkg::ST_W-1:0]      out_status;
  logic                          out_last;
  logic                          cfg_wr_en = 1'b0;
  logic                          cfg_index = mss_pkg::REG_HALF_SIZE;
  logic [mss_pkg::HS_W-1:0]      cfg_wr_data = '0;

  mirrored_stripe_request_splitter #(
    .MAX_DEVICES(N_DEV),
    .MAX_PAIRS  (N_PAIRS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_offset  (in_start_offset),
    .in_length        (in_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_device_id    (out_device_id),
    .out_device_offset(out_device_offset),
    .out_piece_length (out_piece_length),
    .out_mirror       (out_mirror),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  // requests waiting to be offered, pieces waiting to be seen
  req_t   todo_requests[$];
  piece_t awaited_pieces[$];

  // shadow of the two registers, raw as written
  logic [mss_pkg::HS_W-1:0]      half_reg  = mss_pkg::HALF_RESET;
  logic [mss_pkg::CNT_CFG_W-1:0] count_reg = mss_pkg::COUNT_RESET;

  int mismatches = 0;

  // handshake bookkeeping, sampled at the rising edge
  bit in_took  = 1'b0;
  bit out_took = 1'b0;

  // sender and receiver pacing
  int in_gap   = 0;
  bit in_calm  = 1'b0;
  int out_wait = 0;
  bit out_calm = 1'b0;
  int out_hold = 0;
  int hold_asked  = 0;
  int hold_served = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // half size as the block uses it: zero reads as one, saturate at 2^32
  function automatic logic [63:0] eff_half();
    logic [63:0] h;
    h = {31'b0, half_reg};
    if (h == 64'd0) h = 64'd1;
    if (h > {31'b0, mss_pkg::HALF_MAX}) h = {31'b0, mss_pkg::HALF_MAX};
    return h;
  endfunction

  // ring size saturated into [2, N_DEV]
  function automatic logic [63:0] eff_count();
    logic [63:0] c;
    c = {59'b0, count_reg};
    if (c < 64'd2) c = 64'd2;
    if (c > 64'(N_DEV)) c = 64'(N_DEV);
    return c;
  endfunction

  // split one request into primary/mirror pairs and queue them up
  function automatic void split_request(input logic [mss_pkg::OFF_W-1:0] offs,
                                        input logic [mss_pkg::LEN_W-1:0] len);
    logic [63:0] hs, cnt, id, bid, poff, boff, room, rem, chunk;
    int pairs;
    bit done, trunc;
    piece_t p;
    hs  = eff_half();
    cnt = eff_count();
    id  = {28'b0, offs} / hs;
    if (id >= cnt) begin
      // out-of-range start: single flagged result, all else zero
      p.dev = '0; p.offs = '0; p.len = '0; p.bk = 1'b0;
      p.st = mss_pkg::STAT_OOR; p.is_last = 1'b1;
      awaited_pieces.insert(awaited_pieces.size(), p);
      return;
    end
    poff  = {28'b0, offs} - id * hs;
    room  = hs - poff;
    rem   = {32'b0, len};
    pairs = 0;
    done  = 1'b0;
    while (!done) begin
      bid   = (id + 64'd1 == cnt) ? 64'd0 : id + 64'd1;
      chunk = (rem < room) ? rem : room;
      rem   = rem - chunk;
      pairs++;
      trunc = (rem != 0) && (pairs >= N_PAIRS);
      done  = (rem == 0) || trunc;
      p.dev = id[mss_pkg::DEVID_W-1:0]; p.offs = poff[mss_pkg::HS_W-1:0];
      p.len = chunk[mss_pkg::LEN_W-1:0];
      p.bk = 1'b0; p.st = mss_pkg::STAT_OK; p.is_last = 1'b0;
      awaited_pieces.insert(awaited_pieces.size(), p);
      // mirror copy lives on the next device, upper half
      boff  = poff + hs;
      p.dev = bid[mss_pkg::DEVID_W-1:0]; p.offs = boff[mss_pkg::HS_W-1:0]; p.bk = 1'b1;
      p.st = trunc ? mss_pkg::STAT_TRUNC : mss_pkg::STAT_OK; p.is_last = done;
      awaited_pieces.insert(awaited_pieces.size(), p);
      id   = bid;
      poff = 64'd0;
      room = hs;
    end
  endfunction

  // random request shaped by the current ring: mostly in-range spans
  function automatic req_t make_request();
    req_t r;
    logic [63:0] hs, cnt, id, poff, room, ln, lo;
    hs   = eff_half();
    cnt  = eff_count();
    lo   = rand64();
    r.offs = lo[mss_pkg::OFF_W-1:0];
    r.len  = $urandom;
    id   = 64'($urandom_range(0, int'(cnt) - 1));
    poff = rand64() % hs;
    room = hs - poff;
    lo   = id * hs + poff;
    case ($urandom_range(0, 9))
      0: ;  // plain noise over the full field ranges
      1: begin
        // just past the end of the ring
        ln = cnt * hs + (rand64() % 64'd4096);
        if (ln < 64'h10_0000_0000) r.offs = ln[mss_pkg::OFF_W-1:0];
      end
      2: begin
        r.offs = lo[mss_pkg::OFF_W-1:0];
        r.len  = '0;
      end
      default: begin
        r.offs = lo[mss_pkg::OFF_W-1:0];
        case ($urandom_range(0, 3))
          0:       ln = rand64() % (room + 64'd1);
          1:       ln = room + 64'($urandom_range(0, 40)) * hs + rand64() % hs;
          2:       ln = room;
          default: ln = $urandom_range(0, 1) ? 64'hFFFF_FFFF : {32'b0, $urandom};
        endcase
        r.len = (ln > 64'hFFFF_FFFF) ? $urandom : ln[mss_pkg::LEN_W-1:0];
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: accept tracking and prediction at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) split_request(in_start_offset, in_length);
  end

  // driver: offers the next queued request at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        // draw the wait before the next item; calm stretches have none
        in_gap = in_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
      end
      if (in_valid && !in_took) begin
        // still waiting on the block, payload holds
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (todo_requests.size() != 0) begin
        req_t r;
        r = todo_requests.pop_front();
        in_start_offset <= r.offs;
        in_length       <= r.len;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output side: monitor at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    piece_t want;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_pieces.size() == 0) begin
        report_mismatch("result with nothing awaited, device_offset",
                        64'(out_device_offset), 64'd0);
      end else begin
        want = awaited_pieces.pop_front();
        if (out_device_id !== want.dev)
          report_mismatch("device_id", 64'(out_device_id), 64'(want.dev));
        if (out_device_offset !== want.offs)
          report_mismatch("device_offset", 64'(out_device_offset), 64'(want.offs));
        if (out_piece_length !== want.len)
          report_mismatch("piece_length", 64'(out_piece_length), 64'(want.len));
        if (out_mirror !== want.bk)
          report_mismatch("mirror", 64'(out_mirror), 64'(want.bk));
        if (out_status !== want.st)
          report_mismatch("status", 64'(out_status), 64'(want.st));
        if (out_last !== want.is_last)
          report_mismatch("last", 64'(out_last), 64'(want.is_last));
      end
    end
  end

  // receiver stall: random per item, plus one long hold on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_hold = 400;
      end
      if (out_took) begin
        out_wait = out_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_request(input logic [mss_pkg::OFF_W-1:0] offs,
                             input logic [mss_pkg::LEN_W-1:0] len);
    req_t r;
    r.offs = offs;
    r.len  = len;
    todo_requests.insert(todo_requests.size(), r);
  endtask

  // wait until every queued item went in and every piece came out
  task automatic drain();
    while (todo_requests.size() != 0 || in_valid || awaited_pieces.size() != 0)
      @(posedge clk);
    // allow for the return cycle after the final piece
    repeat (10) @(posedge clk);
  endtask

  // both registers, one per cycle; only called while the block is idle
  task automatic write_regs(input logic [mss_pkg::HS_W-1:0] hs_word,
                            input logic [mss_pkg::HS_W-1:0] cnt_word);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= mss_pkg::REG_HALF_SIZE;
    cfg_wr_data <= hs_word;
    half_reg = hs_word;
    @(negedge clk);
    cfg_index   <= mss_pkg::REG_DEVICE_COUNT;
    cfg_wr_data <= cnt_word;
    count_reg = cnt_word[mss_pkg::CNT_CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [mss_pkg::HS_W-1:0] hs_w, cnt_w;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset ring: 1 MiB halves, four devices
    add_request('0, '0);                                   // zero length
    add_request(36'hF_FFFF_FFFF, 32'hFFFF_FFFF);           // max fields, out of range
    add_request(36'd4 << 20, 32'd1);                       // first byte past the ring
    add_request((36'd4 << 20) - 36'd1, 32'd1);             // last byte of the ring
    add_request((36'd3 << 20) + 36'd5, 32'd2 << 20);       // wraps onto device 0
    add_request('0, 32'hFFFF_FFFF);                        // far too many pieces
    add_request((36'd1 << 20) - 36'd1, 32'd2);             // straddles a boundary
    add_request(36'd1 << 20, 32'd1 << 20);                 // exactly one half
    add_request('0, 32'd32 << 20);                         // exactly the pair limit
    add_request('0, (32'd32 << 20) + 32'd1);               // one byte over the limit
    drain();

    // zero half size and tiny ring: one-byte pieces bouncing between two devices
    write_regs('0, '0);
    add_request('0, 32'hFFFF_FFFF);
    add_request(36'd1, 32'd3);
    add_request(36'd2, '0);
    drain();

    // oversize half and count both saturate: widest offsets in the ring
    write_regs(33'h1_FFFF_FFFF, 33'd31);
    add_request(36'hF_FFFF_FFFF, 32'hFFFF_FFFF);           // device 15 wraps to 0
    add_request('0, 32'hFFFF_FFFF);
    add_request(36'd15 << 32, '0);
    drain();

    // exact upper limits
    write_regs(mss_pkg::HALF_MAX, 33'd16);
    add_request(36'hA_5A5A_5A5A, 32'h5A5A_A5A5);
    add_request(36'd1 << 32, 32'd1);
    drain();

    // lower limits, count below the floor
    write_regs(33'd1, 33'd1);
    add_request(36'd1, 32'd2);
    add_request('0, 32'd33);
    drain();

    // small halves, count just over the ceiling
    write_regs(33'd3, 33'd17);
    add_request(36'd47, 32'd5);
    add_request(36'd48, 32'd1);
    drain();

    // random phases, each under a fresh ring setting
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0:       hs_w = 33'($urandom_range(1, 64));
        1:       hs_w = 33'($urandom_range(1, 5000));
        2:       hs_w = {1'b0, $urandom};
        3:       hs_w = {1'($urandom_range(0, 1)), $urandom};
        4:       hs_w = mss_pkg::HALF_MAX;
        default: hs_w = 33'($urandom_range(0, 3));
      endcase
      cnt_w = {1'($urandom_range(0, 1)), $urandom};
      write_regs(hs_w, cnt_w);
      for (int k = 0; k < 11; k++) todo_requests.insert(todo_requests.size(), make_request());
      // one long output hold so the block backs up into its input
      if (ph == 2) hold_asked++;
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ mirrored_stripe_request_splitter.f @@
sv/mss_pkg.sv
sv/mss_seq.sv
sv/mss_dp.sv
sv/mirrored_stripe_request_splitter.sv
bench/testbench.sv
